>>> rtl/core/cdq_pkg.sv
package cdq_pkg;

  localparam int DATA_W  = 32;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;   // apply the accepted action
    logic fill;   // load the front/rear cache from the read data
  } cdq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_fill;  // the action being applied leaves a new end to fetch
  } cdq_stat_t;

endpackage

>>> rtl/core/cdq_intf.sv
interface cdq_req_if import cdq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       count;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output data_out, output status, output count,
                  output front_value, output rear_value, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input data_out, input status, input count,
                  input front_value, input rear_value, input is_empty,
                  input is_full, output ready);
endinterface

interface cdq_cfg_if import cdq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

>>> rtl/core/cdq_ctrl.sv
module cdq_ctrl import cdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  cdq_stat_t stat,
  output cdq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.exec   = 1'b1;
          state_next = stat.need_fill ? S_FILL : S_OUT;
        end
      end
      S_FILL: begin
        cmd.fill   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/cdq_datapath.sv
module cdq_datapath import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cdq_cmd_t                 cmd,
  output cdq_stat_t                stat,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_capacity,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [DATA_W-1:0] data_in,
  output logic signed [DATA_W-1:0] data_out,
  output logic [STAT_W-1:0]        status,
  output logic [COUNT_W-1:0]       count,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] rear_value,
  output logic                     is_empty,
  output logic                     is_full
);

  localparam int IW     = $clog2(DEPTH);
  localparam int CapMax = (DEPTH < 31) ? DEPTH : 31;

  logic [CAP_W-1:0]   capacity;
  logic [COUNT_W-1:0] occupancy;
  logic [IW-1:0]      head;
  logic [IW-1:0]      tail;
  logic [DATA_W-1:0]  front_reg;
  logic [DATA_W-1:0]  rear_reg;
  logic [DATA_W-1:0]  data_out_reg;
  status_t            status_reg;
  logic               fill_front;

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  rdata;

  logic [CAP_W-1:0]   cap_eff;
  logic [CAP_W-1:0]   cap_dec;
  logic [IW-1:0]      cap_m1;
  action_t            act;

  logic [COUNT_W-1:0] occupancy_next;
  logic [IW-1:0]      head_next;
  logic [IW-1:0]      tail_next;
  logic [DATA_W-1:0]  front_next;
  logic [DATA_W-1:0]  rear_next;
  logic [DATA_W-1:0]  popped;
  status_t            status_next;
  logic               fill_front_next;
  logic               we;
  logic [IW-1:0]      waddr;
  logic               re;
  logic [IW-1:0]      raddr;

  // Clamp the register to 1..min(DEPTH, 31).
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (capacity > CAP_W'(CapMax)) begin
      cap_eff = CAP_W'(CapMax);
    end else begin
      cap_eff = capacity;
    end
    cap_dec = cap_eff - CAP_W'(1);
    cap_m1  = IW'(cap_dec);
  end

  assign act = action_t'(action);

  always_comb begin
    occupancy_next  = occupancy;
    head_next       = head;
    tail_next       = tail;
    front_next      = front_reg;
    rear_next       = rear_reg;
    popped          = '0;
    status_next     = ST_DONE;
    fill_front_next = fill_front;
    we              = 1'b0;
    waddr           = head;
    re              = 1'b0;
    raddr           = head;
    stat.need_fill  = 1'b0;
    case (act) inside
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (occupancy >= cap_eff) begin
          status_next = ST_FULL;
        end else begin
          we             = 1'b1;
          occupancy_next = occupancy + COUNT_W'(1);
          if (occupancy == '0) begin
            head_next  = '0;
            tail_next  = '0;
            waddr      = '0;
            front_next = data_in;
            rear_next  = data_in;
          end else if (act == ACT_PUSH_FRONT) begin
            head_next  = (head == '0) ? cap_m1 : head - IW'(1);
            waddr      = head_next;
            front_next = data_in;
          end else begin
            tail_next = (tail == cap_m1) ? '0 : tail + IW'(1);
            waddr     = tail_next;
            rear_next = data_in;
          end
        end
      end
      default: begin
        if (occupancy == '0) begin
          status_next = ST_EMPTY;
        end else begin
          occupancy_next = occupancy - COUNT_W'(1);
          if (act == ACT_POP_FRONT) begin
            popped          = front_reg;
            head_next       = (head == cap_m1) ? '0 : head + IW'(1);
            raddr           = head_next;
            fill_front_next = 1'b1;
          end else begin
            popped          = rear_reg;
            tail_next       = (tail == '0) ? cap_m1 : tail - IW'(1);
            raddr           = tail_next;
            fill_front_next = 1'b0;
          end
          // Last entry gone: rewind both pointers, nothing to fetch.
          if (occupancy == COUNT_W'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            re             = 1'b1;
            stat.need_fill = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      occupancy <= '0;
      head      <= '0;
      tail      <= '0;
    end else if (cfg_we) begin
      capacity  <= cfg_capacity;
      occupancy <= '0;
      head      <= '0;
      tail      <= '0;
    end else if (cmd.exec) begin
      occupancy <= occupancy_next;
      head      <= head_next;
      tail      <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      front_reg    <= front_next;
      rear_reg     <= rear_next;
      data_out_reg <= popped;
      status_reg   <= status_next;
      fill_front   <= fill_front_next;
    end else if (cmd.fill) begin
      if (fill_front) begin
        front_reg <= rdata;
      end else begin
        rear_reg <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= data_in;
    end
    if (cmd.exec && re) begin
      rdata <= mem[raddr];
    end
  end

  assign data_out    = data_out_reg;
  assign status      = status_reg;
  assign count       = occupancy;
  assign is_empty    = (occupancy == '0);
  assign is_full     = (occupancy == cap_eff);
  assign front_value = is_empty ? '0 : front_reg;
  assign rear_value  = is_empty ? '0 : rear_reg;

endmodule

>>> rtl/core/circular_deque_core.sv
// Double-ended queue in a ring of DEPTH 32-bit slots, of which the capacity
// register puts 1..min(DEPTH, 31) in use (0 acts as 1, larger values are
// clamped). Each transfer on req carries one action: push front, push rear,
// pop front or pop rear; each one gives exactly one transfer on rsp with the
// popped value (0 unless a pop succeeds), a status (done, full, empty), the
// count and the front and rear entries after the action (0 when empty) and
// empty/full flags. The block works on one action at a time: a push or a
// rejected action goes from the apply step straight to the held result,
// while a pop that leaves entries behind adds a fill step between them for
// the registered read of the single-port slot memory that fetches the new
// front or rear. Writing capacity empties the deque; write it only while
// no action is in flight.
module circular_deque_core import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  cdq_cfg_if.sink cfg,
  cdq_req_if.sink req,
  cdq_rsp_if.source rsp
);

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  // Always taken; user keeps block idle when writes come (not enforced).
  assign cfg.ready = 1'b1;

  // Sequence each action: apply, fetch the new end if needed, hold result.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Pointers, count, slot memory, cached front and rear entries.
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg.valid),
    .cfg_capacity (cfg.capacity),
    .action       (req.action),
    .data_in      (req.data_in),
    .data_out     (rsp.data_out),
    .status       (rsp.status),
    .count        (rsp.count),
    .front_value  (rsp.front_value),
    .rear_value   (rsp.rear_value),
    .is_empty     (rsp.is_empty),
    .is_full      (rsp.is_full)
  );

endmodule

>>> tb/sv/circular_deque_core_tb.sv
module circular_deque_core_tb;
  import cdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 50;

  // One action as the sender hands it to the block.
  typedef struct packed {
    action_t                  act;
    logic signed [DATA_W-1:0] val;
  } deque_op_t;

  // One predicted response transfer.
  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } deque_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdq_cfg_if cfg_bus ();
  cdq_req_if req_bus ();
  cdq_rsp_if rsp_bus ();

  circular_deque_core #(.DEPTH(RING_DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #10 clk = ~clk;

  // Mirror of the deque contents, pointers and capacity register.
  logic signed [DATA_W-1:0] ring_copy [RING_DEPTH];
  int unsigned              head_pos  = 0;
  int unsigned              tail_pos  = 0;
  int unsigned              held      = 0;
  logic [CAP_W-1:0]         cap_reg   = CAP_RESET;

  deque_op_t  action_queue [$];   // actions waiting for the driver
  deque_rsp_t predicted_rsp [$];  // responses owed by the block, oldest first

  int err_count  = 0;
  int cycles     = 0;

  // Sender pacing: bursts of back-to-back actions, then gaps.
  int burst_left = 1;
  int gap_left   = 0;
  logic op_taken = 1'b0;

  // Receiver pacing: a stall pattern that changes mode now and then.
  int ready_mode  = 0;
  int mode_left   = 100;
  int stall_left  = 0;
  int stall_every = 3;

  // Clamp the register to the ring actually in use: 0 acts as 1,
  // anything beyond the storage depth acts as the depth.
  function automatic int unsigned ring_size();
    if (cap_reg == '0) return 1;
    if (int'(cap_reg) > RING_DEPTH) return RING_DEPTH;
    return int'(cap_reg);
  endfunction

  // Apply one action to the mirror and return the response it must produce.
  function automatic deque_rsp_t apply_deque_action(action_t act,
                                                     logic signed [DATA_W-1:0] val);
    deque_rsp_t  r;
    int unsigned eff;
    eff = ring_size();
    r.data_out = '0;
    r.status   = ST_DONE;
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_REAR) begin
      if (held >= eff) begin
        r.status = ST_FULL;
      end else begin
        // First entry of an empty deque always lands in slot 0.
        if (held == 0) begin
          head_pos = 0;
          tail_pos = 0;
          ring_copy[0] = val;
        end else if (act == ACT_PUSH_FRONT) begin
          head_pos = (head_pos == 0) ? eff - 1 : head_pos - 1;
          ring_copy[head_pos] = val;
        end else begin
          tail_pos = (tail_pos + 1 >= eff) ? 0 : tail_pos + 1;
          ring_copy[tail_pos] = val;
        end
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        if (act == ACT_POP_FRONT) begin
          r.data_out = ring_copy[head_pos];
          head_pos = (head_pos + 1 >= eff) ? 0 : head_pos + 1;
        end else begin
          r.data_out = ring_copy[tail_pos];
          tail_pos = (tail_pos == 0) ? eff - 1 : tail_pos - 1;
        end
        held--;
        // Removing the last entry parks both pointers at slot 0.
        if (held == 0) begin
          head_pos = 0;
          tail_pos = 0;
        end
      end
    end
    r.count       = COUNT_W'(held);
    r.front_value = (held != 0) ? ring_copy[head_pos] : '0;
    r.rear_value  = (held != 0) ? ring_copy[tail_pos] : '0;
    r.is_empty    = (held == 0);
    r.is_full     = (held == eff);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (err_count < PRINT_LIMIT)
      $display("%0t ns mismatch %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Acceptance of an action: predict its response at the transfer edge.
  always @(posedge clk) begin
    cycles++;
    if (!rst && req_bus.valid && req_bus.ready) begin
      predicted_rsp.push_back(apply_deque_action(action_t'(req_bus.action),
                                                 req_bus.data_in));
      op_taken = 1'b1;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("circular_deque_core_tb: errors");
      $finish;
    end
  end

  // Driver: hold the current action until it is taken, then advance to the
  // next queued one, or drop valid for a gap between bursts.
  always @(negedge clk) begin
    deque_op_t op;
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || op_taken) begin
      op_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (action_queue.size() > 0) begin
        op = action_queue.pop_front();
        req_bus.valid   <= 1'b1;
        req_bus.action  <= op.act;
        req_bus.data_in <= op.val;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // About a third of the bursts run straight into the next one.
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall according to the current mode; switch modes at random.
  always @(negedge clk) begin
    if (mode_left > 0) begin
      mode_left--;
    end else begin
      ready_mode  = $urandom_range(0, 3);
      mode_left   = $urandom_range(50, 300);
      stall_every = $urandom_range(2, 5);
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
      case (ready_mode)
        0: stall_left = 0;                                  // always ready
        1: stall_left = $urandom_range(0, 1);               // coin toss
        2: stall_left = stall_every - 1;                    // fixed rhythm
        default: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      endcase
    end
  end

  // Monitor: compare every response transfer against the oldest prediction.
  always @(posedge clk) begin
    deque_rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (predicted_rsp.size() == 0) begin
        report_mismatch("unexpected response", DATA_W'(rsp_bus.count), '0);
      end else begin
        want = predicted_rsp.pop_front();
        if (rsp_bus.data_out !== want.data_out)
          report_mismatch("data_out", rsp_bus.data_out, want.data_out);
        if (rsp_bus.status !== want.status)
          report_mismatch("status", DATA_W'(rsp_bus.status), DATA_W'(want.status));
        if (rsp_bus.count !== want.count)
          report_mismatch("count", DATA_W'(rsp_bus.count), DATA_W'(want.count));
        if (rsp_bus.front_value !== want.front_value)
          report_mismatch("front_value", rsp_bus.front_value, want.front_value);
        if (rsp_bus.rear_value !== want.rear_value)
          report_mismatch("rear_value", rsp_bus.rear_value, want.rear_value);
        if (rsp_bus.is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(rsp_bus.is_empty), DATA_W'(want.is_empty));
        if (rsp_bus.is_full !== want.is_full)
          report_mismatch("is_full", DATA_W'(rsp_bus.is_full), DATA_W'(want.is_full));
      end
    end
  end

  // Hold until every queued action is taken and every response has come,
  // then let the block settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (action_queue.size() != 0 || req_bus.valid || predicted_rsp.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the capacity register; only called while the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_bus.valid    <= 1'b1;
    cfg_bus.capacity <= cap;
    do @(posedge clk);
    while (!cfg_bus.ready);
    // The write empties the deque.
    cap_reg  = cap;
    held     = 0;
    head_pos = 0;
    tail_pos = 0;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_op(input action_t act, input logic signed [DATA_W-1:0] val);
    deque_op_t op;
    op.act = act;
    op.val = val;
    action_queue.push_back(op);
  endtask

  // Random word that favors the corners of the signed range now and then.
  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Queue n random actions in runs that lean toward filling, draining or
  // neither, so full and empty are both reached over and over.
  task automatic queue_random_ops(input int n);
    int run_left;
    int push_pct;
    action_t act;
    run_left = 0;
    push_pct = 50;
    repeat (n) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 2 * ring_size() + 6);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      if ($urandom_range(0, 99) < push_pct)
        act = ($urandom_range(0, 1) == 0) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
      else
        act = ($urandom_range(0, 1) == 0) ? ACT_POP_FRONT : ACT_POP_REAR;
      queue_op(act, random_word());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [12];
    int               phase_items;
    // Every input known from time zero.
    cfg_bus.valid    = 1'b0;
    cfg_bus.capacity = '0;
    req_bus.valid    = 1'b0;
    req_bus.action   = ACT_PUSH_FRONT;
    req_bus.data_in  = '0;
    rsp_bus.ready    = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset capacity, pops on empty, pushes and pops at both ends
    // with the extreme values, emptying the deque, and a front push that
    // wraps the head pointer to the top of the ring.
    queue_op(ACT_POP_FRONT,  32'sh1234_5678);
    queue_op(ACT_POP_REAR,   32'sh1234_5678);
    queue_op(ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
    queue_op(ACT_PUSH_REAR,  32'sh8000_0000);
    queue_op(ACT_PUSH_FRONT, '1);
    queue_op(ACT_PUSH_REAR,  '0);
    queue_op(ACT_POP_FRONT,  '0);
    queue_op(ACT_POP_REAR,   '1);
    queue_op(ACT_POP_REAR,   '0);
    queue_op(ACT_POP_FRONT,  '0);
    queue_op(ACT_PUSH_REAR,  32'sh5555_5555);
    queue_op(ACT_PUSH_FRONT, 32'shAAAA_AAAA);
    queue_op(ACT_POP_REAR,   '0);
    queue_op(ACT_POP_FRONT,  '0);
    wait_idle();

    // Capacity of one: the second push is rejected as full.
    write_capacity(5'd1);
    queue_op(ACT_PUSH_FRONT, 32'sh0F0F_0F0F);
    queue_op(ACT_PUSH_REAR,  32'shF0F0_F0F0);
    queue_op(ACT_POP_REAR,   '0);
    queue_op(ACT_POP_FRONT,  '0);
    wait_idle();

    // Capacity of zero behaves as one.
    write_capacity(5'd0);
    queue_op(ACT_PUSH_REAR,  32'sh0000_0001);
    queue_op(ACT_PUSH_FRONT, 32'sh0000_0002);
    queue_op(ACT_POP_FRONT,  '0);
    wait_idle();

    // Random phases over a spread of capacities, extremes included.
    caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd2, 5'd3,
             5'd15, 5'd8, 5'd5, 5'd16, 5'd0};
    caps[11] = CAP_W'($urandom_range(0, 31));
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      phase_items = $urandom_range(70, 85);
      queue_random_ops(phase_items / 2);
      // Pause the sender until every response is back, then resume.
      wait_idle();
      queue_random_ops(phase_items - phase_items / 2);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("circular_deque_core_tb: clean");
    end else begin
      $display("circular_deque_core_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_intf.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_datapath.sv
rtl/core/circular_deque_core.sv
tb/sv/circular_deque_core_tb.sv
